FILE: design/hpbr_pkg.sv
// Shared constants and the digit arithmetic for the held-peak beat rate block.
// No dependencies; used by hpbr_div and held_peak_beat_rate.
package hpbr_pkg;

    localparam int DIGIT_W  = 4;
    localparam int WORD_W   = 32;
    localparam int N_DIGITS = WORD_W / DIGIT_W;
    localparam int DCNT_W   = $clog2(N_DIGITS);

    localparam int SAMPLE_W = 24;
    localparam int HOLD_W   = 16;
    localparam int BPM_W    = 16;

    localparam logic [HOLD_W-1:0] HOLD_RESET    = 16'd400;
    localparam logic [BPM_W-1:0]  MS_PER_MINUTE = 16'd60000;

    typedef logic [DIGIT_W:0] t_digit_diff;

    // a - b - borrow_in; top bit is the borrow out
    function automatic t_digit_diff sub_digit(
        input logic [DIGIT_W-1:0] a,
        input logic [DIGIT_W-1:0] b,
        input logic               bin
    );
        t_digit_diff r;
        r = {1'b0, a} - {1'b0, b} - {{DIGIT_W{1'b0}}, bin};
        return r;
    endfunction

endpackage

FILE: design/hpbr_div.sv
// Restoring divider: 60000 divided by a 32-bit interval, one quotient bit a cycle.
// Depends on hpbr_pkg.
module hpbr_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [hpbr_pkg::WORD_W-1:0]  i_divisor,
    output logic                         o_done,
    output logic [hpbr_pkg::BPM_W-1:0]   o_quotient
);

    localparam int QCNT_W = $clog2(hpbr_pkg::BPM_W);

    logic                          r_busy;
    logic                          r_done;
    logic [QCNT_W-1:0]             r_cnt;
    logic [hpbr_pkg::BPM_W-1:0]    r_rem;
    logic [hpbr_pkg::BPM_W-1:0]    r_q;
    logic [hpbr_pkg::BPM_W:0]      r_div;
    logic                          r_big;

    logic [hpbr_pkg::BPM_W:0]      n_trial;
    logic                          n_fit;

    always_comb begin
        n_trial = {r_rem, r_q[hpbr_pkg::BPM_W-1]};
        n_fit   = !r_big && (n_trial >= r_div);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == QCNT_W'(hpbr_pkg::BPM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_rem <= '0;
            r_q   <= hpbr_pkg::MS_PER_MINUTE;
            r_div <= i_divisor[hpbr_pkg::BPM_W:0];
            r_big <= |i_divisor[hpbr_pkg::WORD_W-1:hpbr_pkg::BPM_W+1];
        end else if (r_busy) begin
            r_rem <= n_fit ? hpbr_pkg::BPM_W'(n_trial - r_div)
                           : n_trial[hpbr_pkg::BPM_W-1:0];
            r_q   <= {r_q[hpbr_pkg::BPM_W-2:0], n_fit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

FILE: design/held_peak_beat_rate.sv
// Held-peak beat rate: optical samples in, one rate result per sample out.
// Depends on hpbr_pkg and hpbr_div.
//
// Each sample is scanned, evaluated, divided when a second peak yields a rate, and then
// placed in the output register. The peak compare, the held-time test and the
// interval are worked out four bits a cycle; the rate comes from a divider that
// produces one quotient bit a cycle. A new sample is accepted while the previous
// result still waits in the output register.
module held_peak_beat_rate (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [hpbr_pkg::HOLD_W-1:0]    i_cfg_peak_hold_ms,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [hpbr_pkg::SAMPLE_W-1:0]  i_sample_value,
    input  logic [hpbr_pkg::WORD_W-1:0]    i_now_ms,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_rate_valid,
    output logic [hpbr_pkg::BPM_W-1:0]     o_rate_bpm,
    output logic                           o_zero_interval
);

    localparam int W  = hpbr_pkg::WORD_W;
    localparam int DW = hpbr_pkg::DIGIT_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_EVAL = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]                      r_state, n_state;
    logic [hpbr_pkg::DCNT_W-1:0]     r_cnt;

    logic [hpbr_pkg::HOLD_W-1:0]     r_hold;
    logic                            r_awaiting;
    logic [W-1:0]                    r_first;
    logic [hpbr_pkg::SAMPLE_W-1:0]   r_peak;
    logic [W-1:0]                    r_peak_ms;

    logic [hpbr_pkg::SAMPLE_W-1:0]   r_samp;
    logic [W-1:0]                    r_now;

    logic [W-1:0] r_w_samp, r_w_peak, r_w_now, r_w_rpm, r_w_first, r_w_hold;
    logic [W-1:0] r_e1, r_e2;
    logic         r_b_cmp, r_b_d, r_b_h, r_b_1, r_b_2, r_nz1, r_nz2;

    logic                            r_res_valid, r_res_zero;
    logic [hpbr_pkg::BPM_W-1:0]      r_res_bpm;

    logic                            r_o_valid, r_o_rate_valid, r_o_zero;
    logic [hpbr_pkg::BPM_W-1:0]      r_o_bpm;

    hpbr_pkg::t_digit_diff n_cmp, n_d, n_h, n_1, n_2;

    logic          n_replaced, n_commit, n_nz, n_start, n_out_free;
    logic [W-1:0]  n_interval;
    logic          w_div_done;
    logic [hpbr_pkg::BPM_W-1:0] w_div_q;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == S_IDLE);
    assign n_out_free  = !r_o_valid || i_ready;

    always_comb begin
        n_cmp = hpbr_pkg::sub_digit(r_w_peak[DW-1:0], r_w_samp[DW-1:0], r_b_cmp);
        n_d   = hpbr_pkg::sub_digit(r_w_now[DW-1:0], r_w_rpm[DW-1:0], r_b_d);
        n_h   = hpbr_pkg::sub_digit(n_d[DW-1:0], r_w_hold[DW-1:0], r_b_h);
        n_1   = hpbr_pkg::sub_digit(r_w_now[DW-1:0], r_w_first[DW-1:0], r_b_1);
        n_2   = hpbr_pkg::sub_digit(r_w_rpm[DW-1:0], r_w_first[DW-1:0], r_b_2);
    end

    always_comb begin
        n_replaced = r_b_cmp;
        n_commit   = n_replaced ? (r_hold == '0) : !r_b_h;
        n_interval = n_replaced ? r_e1 : r_e2;
        n_nz       = n_replaced ? r_nz1 : r_nz2;
        n_start    = (r_state == S_EVAL) && n_commit && r_awaiting && n_nz;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid) n_state = S_SCAN;
            S_SCAN: if (r_cnt == hpbr_pkg::DCNT_W'(hpbr_pkg::N_DIGITS - 1)) n_state = S_EVAL;
            S_EVAL: n_state = n_start ? S_DIV : S_OUT;
            S_DIV:  if (w_div_done) n_state = S_OUT;
            S_OUT:  if (n_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_hold     <= hpbr_pkg::HOLD_RESET;
            r_awaiting <= 1'b0;
            r_first    <= '0;
            r_peak     <= '0;
            r_peak_ms  <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) r_hold <= i_cfg_peak_hold_ms;
            if (r_state == S_IDLE) begin
                r_cnt <= '0;
            end else if (r_state == S_SCAN) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (r_state == S_EVAL) begin
                if (n_replaced) r_peak_ms <= r_now;
                if (n_commit) begin
                    r_peak     <= '0;
                    r_awaiting <= !r_awaiting;
                    if (!r_awaiting) r_first <= n_replaced ? r_now : r_peak_ms;
                end else if (n_replaced) begin
                    r_peak <= r_samp;
                end
            end
            if (r_state == S_OUT && n_out_free) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_samp    <= i_sample_value;
            r_now     <= i_now_ms;
            r_w_samp  <= W'(i_sample_value);
            r_w_peak  <= W'(r_peak);
            r_w_now   <= i_now_ms;
            r_w_rpm   <= r_peak_ms;
            r_w_first <= r_first;
            r_w_hold  <= W'(r_hold);
            r_b_cmp   <= 1'b0;
            r_b_d     <= 1'b0;
            r_b_h     <= 1'b0;
            r_b_1     <= 1'b0;
            r_b_2     <= 1'b0;
            r_nz1     <= 1'b0;
            r_nz2     <= 1'b0;
        end else if (r_state == S_SCAN) begin
            r_w_samp  <= r_w_samp  >> DW;
            r_w_peak  <= r_w_peak  >> DW;
            r_w_now   <= r_w_now   >> DW;
            r_w_rpm   <= r_w_rpm   >> DW;
            r_w_first <= r_w_first >> DW;
            r_w_hold  <= r_w_hold  >> DW;
            r_e1      <= {n_1[DW-1:0], r_e1[W-1:DW]};
            r_e2      <= {n_2[DW-1:0], r_e2[W-1:DW]};
            r_b_cmp   <= n_cmp[DW];
            r_b_d     <= n_d[DW];
            r_b_h     <= n_h[DW];
            r_b_1     <= n_1[DW];
            r_b_2     <= n_2[DW];
            r_nz1     <= r_nz1 || (n_1[DW-1:0] != '0);
            r_nz2     <= r_nz2 || (n_2[DW-1:0] != '0);
        end
        if (r_state == S_EVAL) begin
            r_res_valid <= 1'b0;
            r_res_bpm   <= '0;
            r_res_zero  <= n_commit && r_awaiting && !n_nz;
        end else if (r_state == S_DIV && w_div_done) begin
            r_res_valid <= 1'b1;
            r_res_bpm   <= w_div_q;
        end
        if (r_state == S_OUT && n_out_free) begin
            r_o_rate_valid <= r_res_valid;
            r_o_bpm        <= r_res_bpm;
            r_o_zero       <= r_res_zero;
        end
    end

    hpbr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (n_start),
        .i_divisor  (n_interval),
        .o_done     (w_div_done),
        .o_quotient (w_div_q)
    );

    assign o_valid         = r_o_valid;
    assign o_rate_valid    = r_o_rate_valid;
    assign o_rate_bpm      = r_o_bpm;
    assign o_zero_interval = r_o_zero;

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide state");

    a_out_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && n_out_free) |=> o_valid)
        else $error("result not placed in the output register");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_rate_valid && o_zero_interval))
        else $error("rate and zero interval flagged together");

    a_bpm_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_rate_valid) |-> (o_rate_bpm == '0))
        else $error("rate nonzero without a valid rate");

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// Testbench for held_peak_beat_rate: directed and random sample trains with
// a local peak-hold predictor checked against every result. Needs hpbr_pkg.
module tb_top;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic                       rate_valid;
        logic [hpbr_pkg::BPM_W-1:0] rate_bpm;
        logic                       zero_interval;
    } t_beat_result;

    logic                          i_clk              = 1'b0;
    logic                          i_rst_n            = 1'b0;
    logic                          i_cfg_valid        = 1'b0;
    logic [hpbr_pkg::HOLD_W-1:0]   i_cfg_peak_hold_ms = '0;
    logic                          i_valid            = 1'b0;
    logic [hpbr_pkg::SAMPLE_W-1:0] i_sample_value     = '0;
    logic [hpbr_pkg::WORD_W-1:0]   i_now_ms           = '0;
    logic                          i_ready            = 1'b0;
    logic                          o_cfg_ready;
    logic                          o_ready;
    logic                          o_valid;
    logic                          o_rate_valid;
    logic [hpbr_pkg::BPM_W-1:0]    o_rate_bpm;
    logic                          o_zero_interval;

    held_peak_beat_rate i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_peak_hold_ms (i_cfg_peak_hold_ms),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_sample_value     (i_sample_value),
        .i_now_ms           (i_now_ms),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_rate_valid       (o_rate_valid),
        .o_rate_bpm         (o_rate_bpm),
        .o_zero_interval    (o_zero_interval)
    );

    // predictor state
    logic [hpbr_pkg::HOLD_W-1:0]   hold_ms = hpbr_pkg::HOLD_RESET;
    logic                          awaiting_second = 1'b0;
    logic [hpbr_pkg::WORD_W-1:0]   first_peak_ms = '0;
    logic [hpbr_pkg::SAMPLE_W-1:0] peak_val = '0;
    logic [hpbr_pkg::WORD_W-1:0]   peak_ms = '0;

    t_beat_result pending_rates[$];

    int send_idle_pct  = 11;
    int recv_stall_pct = 68;
    int n_mismatch     = 0;
    int n_samples      = 0;
    int n_rates        = 0;
    int n_zero_ivals   = 0;
    int n_holds        = 0;
    int stall_cycles   = 0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_beat_result predict_beat(
        input logic [hpbr_pkg::SAMPLE_W-1:0] s,
        input logic [hpbr_pkg::WORD_W-1:0]   t
    );
        t_beat_result r;
        logic [hpbr_pkg::WORD_W-1:0] held;
        logic [hpbr_pkg::WORD_W-1:0] ival;
        logic [hpbr_pkg::WORD_W-1:0] quot;
        r = '0;
        if (s > peak_val) begin
            peak_val = s;
            peak_ms  = t;
        end
        held = t - peak_ms;
        if (held >= {16'd0, hold_ms}) begin
            if (!awaiting_second) begin
                first_peak_ms   = peak_ms;
                awaiting_second = 1'b1;
            end else begin
                ival = peak_ms - first_peak_ms;
                awaiting_second = 1'b0;
                if (ival == '0) begin
                    r.zero_interval = 1'b1;
                end else begin
                    quot = {16'd0, hpbr_pkg::MS_PER_MINUTE} / ival;
                    r.rate_valid = 1'b1;
                    r.rate_bpm   = quot[hpbr_pkg::BPM_W-1:0];
                end
            end
            peak_val = '0;
        end
        return r;
    endfunction

    task automatic send_sample(input logic [hpbr_pkg::SAMPLE_W-1:0] s,
                               input logic [hpbr_pkg::WORD_W-1:0]   t);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_sample_value <= s;
        i_now_ms       <= t;
        do @(posedge i_clk); while (!o_ready);
        pending_rates.push_back(predict_beat(s, t));
        n_samples++;
    endtask

    task automatic wait_results_idle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_rates.size() != 0);
    endtask

    task automatic write_hold(input logic [hpbr_pkg::HOLD_W-1:0] h);
        wait_results_idle();
        i_cfg_valid        <= 1'b1;
        i_cfg_peak_hold_ms <= h;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        hold_ms = h;
        n_holds++;
    endtask

    task automatic test_default_hold();
        send_sample(24'd0,        32'd0);
        send_sample(24'hFFFFFF,   32'd100);
        send_sample(24'hFFFFFF,   32'd300);
        send_sample(24'd5,        32'd500);
        send_sample(24'd1000,     32'd700);
        send_sample(24'd0,        32'd1100);
        send_sample(24'd0,        32'd1500);
        send_sample(24'd0,        32'd1600);
        send_sample(24'd7,        32'hFFFFFFFF);
        send_sample(24'd0,        32'd398);
        send_sample(24'd0,        32'd399);
        send_sample(24'd9,        32'd59999);
        send_sample(24'd0,        32'd60399);
        send_sample(24'd3,        32'd70000);
        send_sample(24'd0,        32'd70400);
        send_sample(24'd4,        32'd140001);
        send_sample(24'd0,        32'd140401);
        send_sample(24'h800000,   32'd1000);
        send_sample(24'd0,        32'd500);
        send_sample(24'd1,        32'd1001);
        send_sample(24'd0,        32'd1401);
    endtask

    task automatic test_hold_zero();
        write_hold(16'd0);
        send_sample(24'h123456, 32'd42);
        send_sample(24'h123456, 32'd42);
        send_sample(24'd0,      32'd7);
        send_sample(24'hABCDEF, 32'd9);
    endtask

    task automatic test_beats(input int unsigned hold, input int unsigned dt_max,
                              input int n);
        logic [hpbr_pkg::WORD_W-1:0]   t;
        logic [hpbr_pkg::WORD_W-1:0]   r;
        logic [hpbr_pkg::SAMPLE_W-1:0] amp;
        logic [hpbr_pkg::SAMPLE_W-1:0] s;
        logic [hpbr_pkg::SAMPLE_W-1:0] last;
        int unsigned                   len;
        int unsigned                   pos;
        int unsigned                   shift;
        int unsigned                   roll;
        write_hold(hold[hpbr_pkg::HOLD_W-1:0]);
        t    = $urandom;
        last = '0;
        pos  = 0;
        len  = 0;
        amp  = '0;
        for (int k = 0; k < n; k++) begin
            if (pos >= len) begin
                r   = $urandom;
                amp = r[hpbr_pkg::SAMPLE_W-1:0] | 24'd1;
                len = $urandom_range(12, 4);
                pos = 0;
            end
            roll = $urandom_range(99);
            if (roll < 6) begin
                // noise: arbitrary value at an arbitrary time
                r = $urandom;
                s = r[hpbr_pkg::SAMPLE_W-1:0];
                send_sample(s, $urandom);
            end else begin
                t += $urandom_range(dt_max, 0);
                if (roll < 12) begin
                    s = '0;
                end else if (roll < 18) begin
                    s = last;
                end else begin
                    shift = (pos <= len / 2) ? len / 2 - pos : pos - len / 2;
                    s = amp >> shift;
                end
                send_sample(s, t);
            end
            last = s;
            pos++;
        end
    endtask

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_beat_result got;
        t_beat_result want;
        if (i_rst_n && o_valid && i_ready) begin
            got = {o_rate_valid, o_rate_bpm, o_zero_interval};
            if (got.rate_valid)    n_rates++;
            if (got.zero_interval) n_zero_ivals++;
            if (pending_rates.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= MAX_REPORTS)
                    $display("%0t: unexpected result valid=%0b bpm=%0d zero=%0b", $realtime,
                             got.rate_valid, got.rate_bpm, got.zero_interval);
            end else begin
                want = pending_rates.pop_front();
                if (got.rate_valid != want.rate_valid || got.rate_bpm != want.rate_bpm ||
                    got.zero_interval != want.zero_interval) begin
                    n_mismatch++;
                    if (n_mismatch <= MAX_REPORTS)
                        $display("%0t: mismatch exp valid=%0b bpm=%0d zero=%0b,",
                                 $realtime, want.rate_valid, want.rate_bpm,
                                 want.zero_interval,
                                 " got valid=%0b bpm=%0d zero=%0b",
                                 got.rate_valid, got.rate_bpm, got.zero_interval);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                     WATCHDOG_LIMIT, pending_rates.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        int unsigned rand_hold;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct  = 11;
        recv_stall_pct = 68;
        test_default_hold();
        test_hold_zero();
        test_beats(400, 60, 120);
        test_beats(1, 3, 110);

        send_idle_pct  = 68;
        recv_stall_pct = 11;
        test_beats(65535, 20000, 120);
        rand_hold = $urandom_range(65535, 1);
        test_beats(rand_hold, rand_hold / 4 + 1, 110);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_beats(0, 50, 60);
        test_beats(900, 120, 120);

        wait_results_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Ran %0d samples over %0d hold settings: %0d rates, %0d zero intervals.",
                 n_samples, n_holds + 1, n_rates, n_zero_ivals);
        if (n_mismatch == 0 && pending_rates.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches, %0d results missing", n_mismatch,
                     pending_rates.size());
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
